### rtl/core/bra_pkg.sv
`default_nettype none

package bra_pkg;

    // The bitmap is stored as words of this many blocks each.
    localparam int WORD_W = 32;

    localparam int CMD_W       = 1;
    localparam int REQ_LEN_W   = 13;
    localparam int REL_INDEX_W = 12;
    localparam int START_W     = 12;
    localparam int GRANT_W     = 13;
    localparam int TOTAL_W     = 32;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    // Index of the lowest set bit, or WORD_W when no bit is set.
    function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [5:0] idx;
        idx = 6'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bitmap_run_allocator.sv
`default_nettype none

// Channel | Direction | Signals                          | Item
// --------+-----------+----------------------------------+--------------------------------
// s_*     | in        | s_tvalid s_tready s_tdata s_tuser | command with length or index
// m_*     | out       | m_tvalid m_tready m_tdata m_tuser | found flag, start, length, total
//
// After reset the block sweeps the bitmap clear, one word per cycle; s_tready stays low until
// the sweep is done. An allocate reads and searches one bitmap word at a time until it finds
// a free block, marks the first word of the run, then reads and marks each further word the
// run spans and hands off the item (no mark on a failure). The single read port of the bitmap
// memory and the one word-wide mark unit hold it to one word at a time. A release reads the
// word of the block, clears its bit and hands off the item. A stalled result waits in the output register.
module bitmap_run_allocator #(
    parameter int unsigned NUM_BLOCKS = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Bits from the lowest up: request_len[12:0], release_index[24:13], zero fill.
    input  wire logic [bra_pkg::S_TDATA_W-1:0]  s_tdata,
    // Bits from the lowest up: command[0].
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Bits from the lowest up: start_index[11:0], granted_len[24:12],
    // total_allocated[56:25], zero fill.
    output logic [bra_pkg::M_TDATA_W-1:0]       m_tdata,
    // Bits from the lowest up: found[0].
    output logic                                m_tuser
);

    import bra_pkg::*;

    // Geometry of the word-organized bitmap.
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IW        = AW + 5;
    localparam int RW        = (IW + 1 > REL_INDEX_W + 1) ? IW + 1 : REL_INDEX_W + 1;
    localparam int LASTV     = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
    localparam int CNTW      = $clog2(NUM_WORDS + 2);

    localparam logic [AW-1:0]   LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [CNTW-1:0] CNT_LAST  = CNTW'(NUM_WORDS);
    localparam logic [5:0]      LASTV6    = 6'(LASTV);
    localparam logic [32:0]     LAST_ONES = (33'd1 << LASTV) - 33'd1;
    // Bits of the last word past the end of the bitmap always read as used.
    localparam logic [WORD_W-1:0] LAST_INV = ~LAST_ONES[WORD_W-1:0];

    // Sequencer states.
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_S_RD  = 4'd2;
    localparam logic [3:0] ST_SRCH  = 4'd3;
    localparam logic [3:0] ST_M_RD  = 4'd4;
    localparam logic [3:0] ST_MARK  = 4'd5;
    localparam logic [3:0] ST_R_RD  = 4'd6;
    localparam logic [3:0] ST_R_WR  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    // Bitmap memory, one bit per block, set means used.
    logic [WORD_W-1:0] bitmap_mem [NUM_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [AW-1:0]      cur_word_reg, cur_word_next;
    logic [4:0]         cur_off_reg, cur_off_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [AW-1:0]      work_word_reg, work_word_next;
    logic [4:0]         work_off_reg, work_off_next;
    logic [AW-1:0]      start_word_reg, start_word_next;
    logic [4:0]         start_off_reg, start_off_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [GRANT_W-1:0] want_reg, want_next;
    logic [GRANT_W-1:0] got_reg, got_next;

    // Result waiting for the output register.
    logic               res_found_reg, res_found_next;
    logic [START_W-1:0] res_start_reg, res_start_next;
    logic [GRANT_W-1:0] res_len_reg, res_len_next;
    logic [TOTAL_W-1:0] res_total_reg, res_total_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [START_W-1:0] m_start_reg, m_start_next;
    logic [GRANT_W-1:0] m_len_reg, m_len_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;

    // Shared word-wide scan and mark unit.
    logic [WORD_W-1:0]  inv_mask;
    logic [WORD_W-1:0]  free_word;
    logic [WORD_W-1:0]  free_sh;
    logic [5:0]         first_free;
    logic [5:0]         run_len;
    logic [GRANT_W-1:0] remain;
    logic [5:0]         step;
    logic [32:0]        ones33;
    logic [WORD_W-1:0]  mark_mask;
    logic [5:0]         sum6;
    logic               wrap_end;
    logic [AW-1:0]      word_inc;
    logic [GRANT_W-1:0] got_sum;
    logic               run_goes_on;
    logic [4:0]         found_off;

    // Release decoding.
    logic [RW-1:0]      rel_ext;
    logic               rel_out_of_range;
    logic [IW+11:0]     start_ext;

    assign inv_mask   = (work_word_reg == LAST_WORD) ? LAST_INV : '0;
    assign free_word  = ~(rd_data_reg | inv_mask);
    assign free_sh    = free_word >> work_off_reg;
    assign first_free = lowest_set(free_sh);
    assign run_len    = lowest_set(~free_sh);
    assign remain     = want_reg - got_reg;
    assign step       = (remain < GRANT_W'(run_len)) ? remain[5:0] : run_len;
    assign ones33     = (33'd1 << step) - 33'd1;
    assign mark_mask  = ones33[WORD_W-1:0] << work_off_reg;
    assign sum6       = {1'b0, work_off_reg} + step;
    assign wrap_end   = (work_word_reg == LAST_WORD) && (sum6 == LASTV6);
    assign word_inc   = (work_word_reg == LAST_WORD) ? '0 : work_word_reg + 1'b1;
    assign got_sum    = got_reg + GRANT_W'(step);
    assign found_off  = work_off_reg + first_free[4:0];
    // The run continues into the next word only if it reached the word end or the
    // bitmap end with blocks still wanted.
    assign run_goes_on = (GRANT_W'(run_len) < remain) && (sum6[5] || wrap_end);

    assign rel_ext          = RW'(s_tdata[REQ_LEN_W +: REL_INDEX_W]);
    assign rel_out_of_range = rel_ext >= RW'(NUM_BLOCKS);
    assign start_ext        = (IW + 12)'({start_word_reg, start_off_reg});

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = M_TDATA_W'({m_total_reg, m_len_reg, m_start_reg});

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_word_next   = cur_word_reg;
        cur_off_next    = cur_off_reg;
        total_next      = total_reg;
        work_word_next  = work_word_reg;
        work_off_next   = work_off_reg;
        start_word_next = start_word_reg;
        start_off_next  = start_off_reg;
        cnt_next        = cnt_reg;
        want_next       = want_reg;
        got_next        = got_reg;
        res_found_next  = res_found_reg;
        res_start_next  = res_start_reg;
        res_len_next    = res_len_reg;
        res_total_next  = res_total_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_found_next    = m_found_reg;
        m_start_next    = m_start_reg;
        m_len_next      = m_len_reg;
        m_total_next    = m_total_reg;
        mem_we          = 1'b0;
        mem_wa          = work_word_reg;
        mem_wd          = rd_data_reg;
        mem_re          = 1'b0;
        mem_ra          = work_word_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                mem_wd        = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_RELEASE)
                    begin
                        work_word_next = rel_ext[AW+4:5];
                        work_off_next  = rel_ext[4:0];
                        if (rel_out_of_range)
                        begin
                            res_found_next = 1'b0;
                            res_start_next = '0;
                            res_len_next   = '0;
                            res_total_next = total_reg;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_R_RD;
                        end
                    end
                    else
                    begin
                        work_word_next = cur_word_reg;
                        work_off_next  = cur_off_reg;
                        want_next      = s_tdata[REQ_LEN_W-1:0];
                        got_next       = '0;
                        cnt_next       = '0;
                        state_next     = ST_S_RD;
                    end
                end
            end
            ST_S_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SRCH;
            end
            ST_SRCH:
            begin
                if (!first_free[5])
                begin
                    work_off_next   = found_off;
                    start_word_next = work_word_reg;
                    start_off_next  = found_off;
                    state_next      = ST_MARK;
                end
                else if (cnt_reg == CNT_LAST)
                begin
                    // Every block is used: the cursor stays where it was.
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    res_len_next   = '0;
                    res_total_next = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cnt_next       = cnt_reg + 1'b1;
                    work_word_next = word_inc;
                    work_off_next  = '0;
                    state_next     = ST_S_RD;
                end
            end
            ST_M_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                mem_we   = 1'b1;
                mem_wd   = rd_data_reg | mark_mask;
                got_next = got_sum;
                if (wrap_end)
                begin
                    work_word_next = '0;
                    work_off_next  = '0;
                end
                else if (sum6[5])
                begin
                    work_word_next = word_inc;
                    work_off_next  = '0;
                end
                else
                begin
                    work_off_next = sum6[4:0];
                end
                if (run_goes_on)
                begin
                    state_next = ST_M_RD;
                end
                else
                begin
                    cur_word_next  = work_word_next;
                    cur_off_next   = work_off_next;
                    total_next     = total_reg + TOTAL_W'(got_sum);
                    res_found_next = 1'b1;
                    res_start_next = start_ext[START_W-1:0];
                    res_len_next   = got_sum;
                    res_total_next = total_reg + TOTAL_W'(got_sum);
                    state_next     = ST_DONE;
                end
            end
            ST_R_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_R_WR;
            end
            ST_R_WR:
            begin
                mem_we         = 1'b1;
                mem_wd         = rd_data_reg & ~(WORD_W'(1) << work_off_reg);
                res_found_next = 1'b1;
                res_start_next = '0;
                res_len_next   = '0;
                res_total_next = total_reg;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_start_next = res_start_reg;
                    m_len_next   = res_len_reg;
                    m_total_next = res_total_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= bitmap_mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cur_word_reg <= '0;
            cur_off_reg  <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cur_word_reg <= cur_word_next;
            cur_off_reg  <= cur_off_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working and result registers carry payload only.
    always_ff @(posedge clk)
    begin
        work_word_reg  <= work_word_next;
        work_off_reg   <= work_off_next;
        start_word_reg <= start_word_next;
        start_off_reg  <= start_off_next;
        cnt_reg        <= cnt_next;
        want_reg       <= want_next;
        got_reg        <= got_next;
        res_found_reg  <= res_found_next;
        res_start_reg  <= res_start_next;
        res_len_reg    <= res_len_next;
        res_total_reg  <= res_total_next;
        m_found_reg    <= m_found_next;
        m_start_reg    <= m_start_next;
        m_len_reg      <= m_len_next;
        m_total_reg    <= m_total_next;
    end

endmodule

`default_nettype wire

### rtl/core/bra_checker.sv
`default_nettype none

module bra_port_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bra_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser
);

    import bra_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item at a time: an accepted item drops ready in the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in progress");

    // A failed item carries neither a start nor a length.
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[START_W+GRANT_W-1:0] == '0)
        else $error("failed result with start or length");

    // A granted length is only ever reported with the found flag.
    a_grant_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[START_W +: GRANT_W] != '0 |-> m_tuser)
        else $error("blocks granted without found flag");

endmodule

bind bitmap_run_allocator bra_port_checker u_bra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
